FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file; clocked on clk, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SPU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spu assertion failed");

// Next-cycle implication.
`define SPU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spu assertion failed");

`endif

FILE: hdl/spu_pkg.sv
// Package: widths, register codes and channel types of the particle update unit.
package spu_pkg;

	localparam int VALUE_BITS = 32;
	localparam int DIV_W = (VALUE_BITS + 2 > 32) ? VALUE_BITS + 2 : 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COGNITIVE_GAIN = 3'd0,
		REG_SOCIAL_GAIN    = 3'd1,
		REG_INERTIA_MAX    = 3'd2,
		REG_INERTIA_MIN    = 3'd3,
		REG_TOTAL_STEPS    = 3'd4,
		REG_BOUNDARY_MODE  = 3'd5
	} cfg_idx_t;

	localparam logic [15:0] RST_COGNITIVE_GAIN = 16'd6128;
	localparam logic [15:0] RST_SOCIAL_GAIN    = 16'd6128;
	localparam logic [15:0] RST_INERTIA_MAX    = 16'd47828;
	localparam logic [15:0] RST_INERTIA_MIN    = 16'd19661;
	localparam logic [15:0] RST_TOTAL_STEPS    = 16'd500;
	localparam logic        RST_BOUNDARY_MODE  = 1'b1;

	typedef struct packed {
		logic [15:0] cognitive_gain;
		logic [15:0] social_gain;
		logic [15:0] inertia_max;
		logic [15:0] inertia_min;
		logic [15:0] total_steps;
		logic        boundary_mode;
	} cfg_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] cur_pos;
		logic signed [VALUE_BITS-1:0] cur_vel;
		logic signed [VALUE_BITS-1:0] own_best;
		logic signed [VALUE_BITS-1:0] group_best;
		logic signed [VALUE_BITS-1:0] lower_bound;
		logic signed [VALUE_BITS-1:0] upper_bound;
		logic [15:0]                  rand_a;
		logic [15:0]                  rand_b;
		logic [15:0]                  iteration;
	} in_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] new_pos;
		logic signed [VALUE_BITS-1:0] new_vel;
		logic                         hit_bound;
	} out_t;

endpackage

FILE: hdl/spu_ifs.sv
// Stream interfaces for the input and result channels.
interface spu_in_if;
	import spu_pkg::*;
	logic valid;
	logic ready;
	in_t  data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface spu_out_if;
	import spu_pkg::*;
	logic valid;
	logic ready;
	out_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: hdl/swarm_particle_update_unit.sv
// Top level: particle swarm velocity and position update for one coordinate.
// Usage:
//   in_ch carries one coordinate per transaction (position, velocity, bests,
//   bounds, two random fractions, iteration). out_ch returns one transaction
//   with new_pos, new_vel and hit_bound for each input, in order.
//   Configuration registers are written through cfg_we/cfg_idx/cfg_wdata
//   while no transaction is in flight.
// Timing:
//   From input to output register the path is one setup stage,
//   the 34-stage inertia divider, five arithmetic stages, the 34-stage
//   wrap-modulo divider and the output register.
//   Throughput is one transaction per cycle unless the output stalls;
//   both dividers are fully pipelined, one quotient bit per stage.
// Reset: arst_n clears all valid bits and loads default register values.
// Backpressure: when the output holds a transaction and out_ch.ready is low,
//   the whole pipeline holds and in_ch.ready drops; nothing is lost.
module swarm_particle_update_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	spu_in_if.sink                          in_ch,
	spu_out_if.source                       out_ch,
	input  logic                            cfg_we,
	input  logic [spu_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [spu_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import spu_pkg::*;
	`include "assert_macros.svh"

	localparam int VB = VALUE_BITS;
	localparam int SUM_W = VB + 8;
	localparam int P0_W = VB + 17;
	localparam int P1_W = VB + 22;

	typedef struct packed {
		logic signed [VB-1:0] pos;
		logic signed [VB-1:0] vel;
		logic signed [VB-1:0] lo;
		logic signed [VB-1:0] hi;
		logic signed [VB:0]   d1;
		logic signed [VB:0]   d2;
		logic [19:0]          rho1;
		logic [19:0]          rho2;
		logic                 neg;
		logic                 use_div;
		logic [15:0]          wmin;
	} kin_t;

	typedef struct packed {
		logic signed [VB:0]   np;
		logic signed [VB-1:0] nv;
		logic signed [VB-1:0] lo;
		logic signed [VB-1:0] hi;
		logic                 below;
		logic                 above;
		logic                 wrap;
	} bnd_t;

	cfg_t cfg;
	logic adv;

	spu_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.cfg      (cfg)
	);

	// pipeline advances unless the output register is full and stalled
	logic v_s7;
	assign adv = !v_s7 || out_ch.ready;
	assign in_ch.ready = adv;

	// stage 1: schedule numerator, random gains, best differences
	logic [15:0]        stage_c;
	logic               le_c;
	logic [15:0]        dstep_c;
	logic signed [16:0] diff_c;
	logic [15:0]        mag_c;
	logic [31:0]        num_c;
	logic [31:0]        g1_c;
	logic [31:0]        g2_c;
	kin_t               kin_c;

	always_comb begin
		stage_c = 16'(((18'(cfg.total_steps)) * 18'd3) >> 2);
		le_c    = (stage_c != '0) && (in_ch.data.iteration <= stage_c);
		dstep_c = stage_c - in_ch.data.iteration;
		diff_c  = $signed({1'b0, cfg.inertia_max}) - $signed({1'b0, cfg.inertia_min});
		mag_c   = diff_c[16] ? 16'(-diff_c) : diff_c[15:0];
		num_c   = 32'(mag_c) * 32'(dstep_c);
		g1_c    = 32'(cfg.cognitive_gain) * 32'(in_ch.data.rand_a);
		g2_c    = 32'(cfg.social_gain) * 32'(in_ch.data.rand_b);
		kin_c.pos     = in_ch.data.cur_pos;
		kin_c.vel     = in_ch.data.cur_vel;
		kin_c.lo      = in_ch.data.lower_bound;
		kin_c.hi      = in_ch.data.upper_bound;
		kin_c.d1      = $signed({in_ch.data.own_best[VB-1], in_ch.data.own_best})
		              - $signed({in_ch.data.cur_pos[VB-1], in_ch.data.cur_pos});
		kin_c.d2      = $signed({in_ch.data.group_best[VB-1], in_ch.data.group_best})
		              - $signed({in_ch.data.cur_pos[VB-1], in_ch.data.cur_pos});
		kin_c.rho1    = g1_c[31:12];
		kin_c.rho2    = g2_c[31:12];
		kin_c.neg     = diff_c[16];
		kin_c.use_div = le_c;
		kin_c.wmin    = cfg.inertia_min;
	end

	logic        v_s1;
	kin_t        kin_s1;
	logic [31:0] num_s1;
	logic [15:0] stage_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kin_s1   <= kin_c;
			num_s1   <= num_c;
			stage_s1 <= stage_c;
		end
	end

	// inertia divider and its side data line
	logic             dv1_v;
	logic [DIV_W-1:0] dv1_q;
	logic [DIV_W-1:0] dv1_r;
	kin_t             side1_s [DIV_W];

	spu_div_pipe u_div_w (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s1),
		.num      (DIV_W'(num_s1)),
		.den      (DIV_W'(stage_s1)),
		.out_valid(dv1_v),
		.quo      (dv1_q),
		.rem      (dv1_r)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			side1_s[0] <= kin_s1;
			for (int k = 1; k < DIV_W; k++) begin
				side1_s[k] <= side1_s[k-1];
			end
		end
	end

	// stage 2: inertia weight
	logic        v_s2;
	kin_t        kin_s2;
	logic [15:0] w_s2;
	logic [15:0] w_c;
	logic [15:0] unused_rem_c;

	always_comb begin
		unused_rem_c = dv1_r[15:0];
		if (!side1_s[DIV_W-1].use_div) begin
			w_c = side1_s[DIV_W-1].wmin;
		end else if (side1_s[DIV_W-1].neg) begin
			w_c = side1_s[DIV_W-1].wmin - dv1_q[15:0];
		end else begin
			w_c = side1_s[DIV_W-1].wmin + dv1_q[15:0];
		end
	end

	// stage 3: three products
	logic                   v_s3;
	logic signed [P0_W-1:0] p0_s3;
	logic signed [P1_W-1:0] p1_s3;
	logic signed [P1_W-1:0] p2_s3;
	logic signed [VB-1:0]   pos_s3, lo_s3, hi_s3;

	// stage 4: floored sum
	logic                   v_s4;
	logic signed [SUM_W-1:0] sum_s4;
	logic signed [VB-1:0]   pos_s4, lo_s4, hi_s4;

	// stage 5: saturated velocity and raw position
	logic                   v_s5;
	logic signed [VB-1:0]   nv_c;
	logic signed [VB-1:0]   nv_s5;
	logic signed [VB:0]     np_s5;
	logic signed [VB-1:0]   lo_s5, hi_s5;
	logic                   fits_c;

	always_comb begin
		fits_c = (&sum_s4[SUM_W-1:VB-1]) || !(|sum_s4[SUM_W-1:VB-1]);
		if (fits_c) begin
			nv_c = sum_s4[VB-1:0];
		end else if (sum_s4[SUM_W-1]) begin
			nv_c = {1'b1, {(VB-1){1'b0}}};
		end else begin
			nv_c = {1'b0, {(VB-1){1'b1}}};
		end
	end

	// stage 6: bound checks and modulo operands
	logic                 v_s6;
	bnd_t                 bnd_s6;
	logic [DIV_W-1:0]     mnum_s6;
	logic [DIV_W-1:0]     mden_s6;
	logic signed [VB:0]   lo_x, hi_x;
	logic signed [VB+1:0] dlo_c, dhi_c;
	bnd_t                 bnd_c;

	always_comb begin
		lo_x = $signed({lo_s5[VB-1], lo_s5});
		hi_x = $signed({hi_s5[VB-1], hi_s5});
		dlo_c = $signed({lo_x[VB], lo_x}) - $signed({np_s5[VB], np_s5});
		dhi_c = $signed({np_s5[VB], np_s5}) - $signed({hi_x[VB], hi_x});
		bnd_c.np    = np_s5;
		bnd_c.nv    = nv_s5;
		bnd_c.lo    = lo_s5;
		bnd_c.hi    = hi_s5;
		bnd_c.below = np_s5 < lo_x;
		bnd_c.above = !(np_s5 < lo_x) && (np_s5 > hi_x);
		bnd_c.wrap  = !cfg.boundary_mode && (hi_s5 > lo_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s2 <= dv1_v;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kin_s2 <= side1_s[DIV_W-1];
			w_s2   <= w_c;

			p0_s3  <= kin_s2.vel * $signed({1'b0, w_s2});
			p1_s3  <= kin_s2.d1 * $signed({1'b0, kin_s2.rho1});
			p2_s3  <= kin_s2.d2 * $signed({1'b0, kin_s2.rho2});
			pos_s3 <= kin_s2.pos;
			lo_s3  <= kin_s2.lo;
			hi_s3  <= kin_s2.hi;

			sum_s4 <= SUM_W'(p0_s3 >>> 16) + SUM_W'(p1_s3 >>> 16) + SUM_W'(p2_s3 >>> 16);
			pos_s4 <= pos_s3;
			lo_s4  <= lo_s3;
			hi_s4  <= hi_s3;

			nv_s5  <= nv_c;
			np_s5  <= $signed({pos_s4[VB-1], pos_s4}) + $signed({nv_c[VB-1], nv_c});
			lo_s5  <= lo_s4;
			hi_s5  <= hi_s4;

			bnd_s6  <= bnd_c;
			mnum_s6 <= bnd_c.below ? DIV_W'(dlo_c) : DIV_W'(dhi_c);
			mden_s6 <= DIV_W'(hi_x - lo_x);
		end
	end

	// wrap-modulo divider and its side data line
	logic             dv2_v;
	logic [DIV_W-1:0] dv2_q;
	logic [DIV_W-1:0] dv2_r;
	bnd_t             side2_s [DIV_W];
	logic             unused_q_c;

	assign unused_q_c = dv2_q[0];

	spu_div_pipe u_div_m (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s6),
		.num      (mnum_s6),
		.den      (mden_s6),
		.out_valid(dv2_v),
		.quo      (dv2_q),
		.rem      (dv2_r)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			side2_s[0] <= bnd_s6;
			for (int k = 1; k < DIV_W; k++) begin
				side2_s[k] <= side2_s[k-1];
			end
		end
	end

	// stage 7: final position, output register
	bnd_t                 fb;
	logic signed [VB+1:0] rem_x;
	logic signed [VB+1:0] fp_c;
	logic                 hit_c;
	out_t                 out_c;
	out_t                 out_s7;

	always_comb begin
		fb    = side2_s[DIV_W-1];
		rem_x = $signed({1'b0, dv2_r[VB:0]});
		hit_c = fb.below || fb.above;
		if (!hit_c) begin
			fp_c = (VB+2)'(fb.np);
		end else if (!fb.wrap) begin
			fp_c = fb.below ? (VB+2)'(fb.lo) : (VB+2)'(fb.hi);
		end else if (fb.below) begin
			fp_c = (VB+2)'(fb.hi) - rem_x;
		end else begin
			fp_c = (VB+2)'(fb.lo) + rem_x;
		end
		out_c.new_pos   = fp_c[VB-1:0];
		out_c.new_vel   = hit_c ? '0 : fb.nv;
		out_c.hit_bound = hit_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= dv2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s7 <= out_c;
		end
	end

	assign out_ch.valid = v_s7;
	assign out_ch.data  = out_s7;

	// checks
	`SPU_ASSERT_IMP(a_hit_zero_vel, out_ch.valid && out_ch.data.hit_bound, out_ch.data.new_vel == '0)
	`SPU_ASSERT_IMP(a_ready_when_empty, !out_ch.valid, in_ch.ready)
	`SPU_ASSERT_NEXT(a_pipe_holds, v_s6 && !adv, v_s6)

endmodule

FILE: hdl/spu_cfg_regs.sv
// Configuration register file with index decode.
module spu_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [spu_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [spu_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output spu_pkg::cfg_t                    cfg
);
	import spu_pkg::*;

	cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cognitive_gain <= RST_COGNITIVE_GAIN;
			cfg_q.social_gain    <= RST_SOCIAL_GAIN;
			cfg_q.inertia_max    <= RST_INERTIA_MAX;
			cfg_q.inertia_min    <= RST_INERTIA_MIN;
			cfg_q.total_steps    <= RST_TOTAL_STEPS;
			cfg_q.boundary_mode  <= RST_BOUNDARY_MODE;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				REG_COGNITIVE_GAIN: cfg_q.cognitive_gain <= cfg_wdata[15:0];
				REG_SOCIAL_GAIN:    cfg_q.social_gain    <= cfg_wdata[15:0];
				REG_INERTIA_MAX:    cfg_q.inertia_max    <= cfg_wdata[15:0];
				REG_INERTIA_MIN:    cfg_q.inertia_min    <= cfg_wdata[15:0];
				REG_TOTAL_STEPS:    cfg_q.total_steps    <= cfg_wdata[15:0];
				REG_BOUNDARY_MODE:  cfg_q.boundary_mode  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/spu_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
module spu_div_pipe (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [spu_pkg::DIV_W-1:0]    num,
	input  logic [spu_pkg::DIV_W-1:0]    den,
	output logic                         out_valid,
	output logic [spu_pkg::DIV_W-1:0]    quo,
	output logic [spu_pkg::DIV_W-1:0]    rem
);
	import spu_pkg::*;

	logic [DIV_W-1:0] vld_s;
	logic [DIV_W-1:0] num_s [DIV_W];
	logic [DIV_W-1:0] rem_s [DIV_W];
	logic [DIV_W-1:0] den_s [DIV_W];

	logic [DIV_W-1:0] pn [DIV_W];
	logic [DIV_W-1:0] pr [DIV_W];
	logic [DIV_W-1:0] pd [DIV_W];
	logic [DIV_W-1:0] nn [DIV_W];
	logic [DIV_W-1:0] nr [DIV_W];
	logic [DIV_W:0]   tr [DIV_W];
	logic [DIV_W-1:0] ge;

	// one shift-and-subtract step per stage
	always_comb begin
		for (int k = 0; k < DIV_W; k++) begin
			if (k == 0) begin
				pn[k] = num;
				pr[k] = '0;
				pd[k] = den;
			end else begin
				pn[k] = num_s[k-1];
				pr[k] = rem_s[k-1];
				pd[k] = den_s[k-1];
			end
			tr[k] = {pr[k], pn[k][DIV_W-1]};
			ge[k] = (tr[k] >= {1'b0, pd[k]});
			nr[k] = ge[k] ? DIV_W'(tr[k] - {1'b0, pd[k]}) : tr[k][DIV_W-1:0];
			nn[k] = {pn[k][DIV_W-2:0], ge[k]};
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[DIV_W-2:0], in_valid};
		end
	end

	// stage data
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_W; k++) begin
				num_s[k] <= nn[k];
				rem_s[k] <= nr[k];
				den_s[k] <= pd[k];
			end
		end
	end

	assign out_valid = vld_s[DIV_W-1];
	assign quo = num_s[DIV_W-1];
	assign rem = rem_s[DIV_W-1];

endmodule
